// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL files that include them.
// MEBW_ASSERT checks on every clk edge outside reset.
// MEBW_ASSERT_ALWAYS checks on every clk edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define MEBW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MEBW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MEBW_ASSERT(lbl, prop, msg)

`define MEBW_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- hdl/mebw_pkg.sv -----
package mebw_pkg;

  localparam int REGISTER_COUNT_DEF = 1024;
  localparam int BUFFER_WORDS_DEF   = 128;

  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;
  localparam int ADDR_W = 12;
  localparam int POS_W  = 8;
  localparam int REG_W  = 10;

  localparam logic [WORD_W-1:0] ERASED_WORD = 16'hffff;
  localparam logic [1:0]        PHASE_LAST  = 2'd3;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_START   = 3'd1,
    OP_POLL    = 3'd2,
    OP_PRELOAD = 3'd3,
    OP_READ    = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_STEP,
    S_BYTE,
    S_WALK_RD,
    S_WALK_CMP,
    S_DONE
  } state_t;

endpackage

// ----- hdl/mebw_ram.sv -----
module mebw_ram #(
  parameter int DEPTH = mebw_pkg::REGISTER_COUNT_DEF,
  parameter int WIDTH = mebw_pkg::WORD_W,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  import mebw_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- hdl/mirrored_eeprom_block_writer.sv -----
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall   | opcode, buffer_index, word_value,
//         |           |                     | reg_address, block_count, eeprom_busy
// out_    | output    | out_valid/out_stall | status, write_valid, write_address,
//         |           |                     | write_byte, read_word, block_active
//
// After reset the copy store is swept to all ones, one register per cycle, over
// every register; in_stall stays high until the sweep ends.
// One item at a time: each passes EXEC and DONE, a read inside the store also READ,
// a poll or a taken start also STEP, then BYTE if it writes. A fourth byte goes on to
// the skip walk, WALK_RD and WALK_CMP per compared register, to a mismatch or block
// end. A stalled out_ channel holds the item in DONE; one result may wait.
module mirrored_eeprom_block_writer #(
  parameter int REGISTER_COUNT = mebw_pkg::REGISTER_COUNT_DEF,
  parameter int BUFFER_WORDS   = mebw_pkg::BUFFER_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_opcode,
  input  logic [6:0]                    in_buffer_index,
  input  logic [mebw_pkg::WORD_W-1:0]   in_word_value,
  input  logic [mebw_pkg::REG_W-1:0]    in_reg_address,
  input  logic [7:0]                    in_block_count,
  input  logic                          in_eeprom_busy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic                          out_write_valid,
  output logic [mebw_pkg::ADDR_W-1:0]   out_write_address,
  output logic [mebw_pkg::BYTE_W-1:0]   out_write_byte,
  output logic [mebw_pkg::WORD_W-1:0]   out_read_word,
  output logic                          out_block_active
);
  import mebw_pkg::*;
  `include "assert_macros.svh"

  // copy store index, next_register counter (holds REGISTER_COUNT itself)
  localparam int AW = $clog2(REGISTER_COUNT);
  localparam int RW = $clog2(REGISTER_COUNT + 1);
  // width for reg_address + block_count against the store size
  localparam int CW = ((RW > REG_W) ? RW : REG_W) + 1;
  // byte address before masking to the port width
  localparam int XW = ((RW + 2) > ADDR_W) ? (RW + 2) : ADDR_W;
  localparam int BA = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;

  state_t state_r, state_nxt;

  // accepted item
  logic [2:0]        op_r;
  logic [6:0]        idx_r;
  logic [WORD_W-1:0] val_r;
  logic [REG_W-1:0]  reg_r;
  logic [7:0]        cnt_r;
  logic              busy_r;

  // block state
  logic [RW-1:0]    nreg_r, nreg_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [POS_W-1:0] len_r, len_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;

  // result under construction
  status_t           res_status_r, res_status_nxt;
  logic              res_wv_r, res_wv_nxt;
  logic [ADDR_W-1:0] res_wa_r, res_wa_nxt;
  logic [BYTE_W-1:0] res_wb_r, res_wb_nxt;
  logic [WORD_W-1:0] res_rd_r, res_rd_nxt;

  // output register
  logic              out_valid_r;
  status_t           out_status_r;
  logic              out_wv_r;
  logic [ADDR_W-1:0] out_wa_r;
  logic [BYTE_W-1:0] out_wb_r;
  logic [WORD_W-1:0] out_rd_r;
  logic              out_act_r;

  // RAM ports
  logic              copy_we, copy_re;
  logic [AW-1:0]     copy_addr;
  logic [WORD_W-1:0] copy_wdata, copy_q;
  logic              buf_we, buf_re;
  logic [BA-1:0]     buf_addr;
  logic [WORD_W-1:0] buf_wdata, buf_q;

  logic              accept;
  logic              out_free;
  logic [CW-1:0]     reg_ext;
  logic [POS_W-1:0]  idx_ext;
  logic              reg_in_store;
  logic              start_range_bad;
  logic              step_go;
  logic              walk_go;
  logic              walk_match;
  logic              clr_last;
  logic [XW-1:0]     byte_addr;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign reg_ext      = CW'(reg_r);
  assign idx_ext      = {1'b0, idx_r};
  assign reg_in_store = (reg_ext < CW'(REGISTER_COUNT));
  assign start_range_bad = (cnt_r > 8'(BUFFER_WORDS)) ||
                           ((reg_ext + CW'(cnt_r)) > CW'(REGISTER_COUNT));
  assign step_go    = (len_r != '0) && !busy_r;
  assign walk_go    = (pos_r < len_r) && (nreg_r < RW'(REGISTER_COUNT));
  assign walk_match = (copy_q == buf_q);
  assign clr_last   = (clr_r == AW'(REGISTER_COUNT - 1));

  // main area at register*2, mirror area one store size further up
  assign byte_addr = XW'({nreg_r, phase_r[0]}) +
                     (phase_r[1] ? XW'(2 * REGISTER_COUNT) : XW'(0));

  mebw_ram #(.DEPTH(REGISTER_COUNT), .WIDTH(WORD_W)) u_copy (
    .clk   (clk),
    .we    (copy_we),
    .re    (copy_re),
    .addr  (copy_addr),
    .wdata (copy_wdata),
    .rdata (copy_q)
  );

  mebw_ram #(.DEPTH(BUFFER_WORDS), .WIDTH(WORD_W)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .re    (buf_re),
    .addr  (buf_addr),
    .wdata (buf_wdata),
    .rdata (buf_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (op_r)
          OP_READ: begin
            state_nxt = reg_in_store ? S_READ : S_DONE;
          end
          OP_START: begin
            if ((len_r != '0) || start_range_bad) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_STEP;
            end
          end
          OP_POLL: state_nxt = S_STEP;
          default: state_nxt = S_DONE;
        endcase
      end
      S_READ:  state_nxt = S_DONE;
      S_STEP:  state_nxt = step_go ? S_BYTE : S_DONE;
      S_BYTE:  state_nxt = (phase_r == PHASE_LAST) ? S_WALK_RD : S_DONE;
      S_WALK_RD:  state_nxt = walk_go ? S_WALK_CMP : S_DONE;
      S_WALK_CMP: state_nxt = walk_match ? S_WALK_RD : S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    nreg_nxt       = nreg_r;
    pos_nxt        = pos_r;
    phase_nxt      = phase_r;
    len_nxt        = len_r;
    clr_nxt        = clr_r;
    res_status_nxt = res_status_r;
    res_wv_nxt     = res_wv_r;
    res_wa_nxt     = res_wa_r;
    res_wb_nxt     = res_wb_r;
    res_rd_nxt     = res_rd_r;
    copy_we    = 1'b0;
    copy_re    = 1'b0;
    copy_addr  = nreg_r[AW-1:0];
    copy_wdata = buf_q;
    buf_we     = 1'b0;
    buf_re     = 1'b0;
    buf_addr   = pos_r[BA-1:0];
    buf_wdata  = {val_r[7:0], val_r[15:8]};
    unique case (state_r)
      S_CLEAR: begin
        copy_we    = 1'b1;
        copy_addr  = clr_r;
        copy_wdata = ERASED_WORD;
        clr_nxt    = clr_r + AW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = ST_OK;
          res_wv_nxt     = 1'b0;
          res_wa_nxt     = '0;
          res_wb_nxt     = '0;
          res_rd_nxt     = '0;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          OP_LOAD: begin
            // swap bytes on entry; drop loads beyond the buffer
            buf_addr = idx_ext[BA-1:0];
            buf_we   = (idx_ext < POS_W'(BUFFER_WORDS));
          end
          OP_PRELOAD: begin
            copy_addr  = reg_ext[AW-1:0];
            copy_wdata = val_r;
            copy_we    = reg_in_store;
          end
          OP_READ: begin
            copy_addr = reg_ext[AW-1:0];
            copy_re   = reg_in_store;
          end
          OP_START: begin
            if (len_r != '0) begin
              res_status_nxt = ST_BUSY;
            end else if (start_range_bad) begin
              res_status_nxt = ST_RANGE;
            end else begin
              len_nxt   = cnt_r;
              pos_nxt   = '0;
              nreg_nxt  = RW'(reg_ext);
              phase_nxt = '0;
            end
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        res_rd_nxt = copy_q;
      end
      S_STEP: begin
        buf_re = step_go;
      end
      S_BYTE: begin
        res_wv_nxt = 1'b1;
        res_wa_nxt = byte_addr[ADDR_W-1:0];
        res_wb_nxt = phase_r[0] ? buf_q[15:8] : buf_q[7:0];
        phase_nxt  = phase_r + 2'd1;
        if (phase_r == PHASE_LAST) begin
          // commit the register to the copy; it matches, so step past it
          copy_we  = 1'b1;
          nreg_nxt = nreg_r + RW'(1);
          pos_nxt  = pos_r + POS_W'(1);
        end
      end
      S_WALK_RD: begin
        if (walk_go) begin
          copy_re = 1'b1;
          buf_re  = 1'b1;
        end else if (pos_r >= len_r) begin
          len_nxt = '0;
        end
      end
      S_WALK_CMP: begin
        if (walk_match) begin
          nreg_nxt = nreg_r + RW'(1);
          pos_nxt  = pos_r + POS_W'(1);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      nreg_r      <= '0;
      pos_r       <= '0;
      phase_r     <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      nreg_r  <= nreg_nxt;
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      idx_r  <= in_buffer_index;
      val_r  <= in_word_value;
      reg_r  <= in_reg_address;
      cnt_r  <= in_block_count;
      busy_r <= in_eeprom_busy;
    end
    res_status_r <= res_status_nxt;
    res_wv_r     <= res_wv_nxt;
    res_wa_r     <= res_wa_nxt;
    res_wb_r     <= res_wb_nxt;
    res_rd_r     <= res_rd_nxt;
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_wv_r     <= res_wv_r;
      out_wa_r     <= res_wa_r;
      out_wb_r     <= res_wb_r;
      out_rd_r     <= res_rd_r;
      out_act_r    <= (len_r != '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_write_valid   = out_wv_r;
  assign out_write_address = out_wa_r;
  assign out_write_byte    = out_wb_r;
  assign out_read_word     = out_rd_r;
  assign out_block_active  = out_act_r;

  `MEBW_ASSERT(a_idle_phase, (state_r == S_IDLE && len_r == '0) |-> (phase_r == '0), "phase left over after block end")
  `MEBW_ASSERT(a_idle_pos, (state_r == S_IDLE && len_r != '0) |-> (pos_r < len_r), "pending block past its length")
  `MEBW_ASSERT(a_idle_reg, (state_r == S_IDLE && len_r != '0) |-> (nreg_r < RW'(REGISTER_COUNT)), "pending register beyond store")
  `MEBW_ASSERT(a_write_ok, (out_valid_r && out_wv_r) |-> (out_status_r == ST_OK), "byte write with refused status")
  `MEBW_ASSERT(a_clear_quiet, (state_r == S_CLEAR) |-> !out_valid_r, "result during clearing pass")

endmodule

// ----- bench/tb_mirrored_eeprom_block_writer.sv -----
module tb_mirrored_eeprom_block_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import mebw_pkg::*;

  localparam int REGS        = REGISTER_COUNT_DEF;
  localparam int BUFW        = BUFFER_WORDS_DEF;
  localparam int ITEM_TARGET = 1600;
  localparam int HOLD_AFTER  = 500;    // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 20000;  // covers the copy sweep, long walks and the hold-off
  localparam int SETTLE      = 50;

  // One input item and one result, at the port widths.
  typedef struct {
    logic [2:0]        op;
    logic [6:0]        idx;
    logic [WORD_W-1:0] val;
    logic [REG_W-1:0]  addr;
    logic [7:0]        cnt;
    logic              busy;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic              wv;
    logic [ADDR_W-1:0] wa;
    logic [BYTE_W-1:0] wb;
    logic [WORD_W-1:0] rd;
    logic              active;
  } resp_t;

  // Shadow of the writer: RAM copy, word buffer and block progress. Every accepted
  // item is applied here and yields the response the block owes for it.
  class writer_shadow;
    logic [WORD_W-1:0] copy_words[REGS];
    logic [WORD_W-1:0] buf_words[BUFW];
    bit                loaded[BUFW];
    int unsigned       cur_reg, buf_pos, block_len;
    logic [1:0]        phase;
    resp_t             responses_due[$];
    int                errors, bytes_issued, starts_refused;

    function new();
      foreach (copy_words[i]) copy_words[i] = ERASED_WORD;
      foreach (buf_words[i]) begin
        buf_words[i] = '0;
        loaded[i] = 1'b0;
      end
      cur_reg = 0;
      buf_pos = 0;
      block_len = 0;
      phase = '0;
    endfunction

    function bit active();
      return block_len != 0;
    endfunction

    function int outstanding();
      return responses_due.size();
    endfunction

    // Number of buffer slots from zero upward that hold a loaded word.
    function int loaded_prefix();
      int n;
      n = 0;
      while (n < BUFW && loaded[n]) n++;
      return n;
    endfunction

    function logic [WORD_W-1:0] fetch_slot(int unsigned pos);
      return (pos < BUFW) ? buf_words[pos] : '0;
    endfunction

    // One write attempt of the pending block.
    function bit emit_byte(logic busy, output logic [ADDR_W-1:0] a,
                           output logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] w;
      int unsigned       full;
      a = '0;
      b = '0;
      if (block_len == 0 || busy) return 1'b0;
      w = fetch_slot(buf_pos);
      full = cur_reg * 2 + phase[0];
      if (phase[1]) full += REGS * 2;
      a = ADDR_W'(full);
      b = phase[0] ? w[15:8] : w[7:0];
      if (phase == PHASE_LAST) begin
        phase = '0;
        if (cur_reg < REGS) copy_words[cur_reg] = w;
        // walk past registers whose copy already holds the buffer word
        while (buf_pos < block_len && cur_reg < REGS &&
               copy_words[cur_reg] == fetch_slot(buf_pos)) begin
          cur_reg++;
          buf_pos++;
        end
        if (buf_pos >= block_len) block_len = 0;
      end else begin
        phase++;
      end
      bytes_issued++;
      return 1'b1;
    endfunction

    function void note_item(req_t r);
      resp_t e;
      e = '0;
      e.status = ST_OK;
      case (r.op)
        OP_LOAD: begin
          if (r.idx < BUFW) begin
            buf_words[r.idx] = {r.val[7:0], r.val[15:8]};
            loaded[r.idx] = 1'b1;
          end
        end
        OP_START: begin
          if (block_len != 0) begin
            e.status = ST_BUSY;
            starts_refused++;
          end else if (int'(r.cnt) > BUFW || int'(r.addr) + int'(r.cnt) > REGS) begin
            e.status = ST_RANGE;
            starts_refused++;
          end else begin
            block_len = r.cnt;
            buf_pos = 0;
            cur_reg = r.addr;
            phase = '0;
            e.wv = emit_byte(r.busy, e.wa, e.wb);
          end
        end
        OP_POLL: e.wv = emit_byte(r.busy, e.wa, e.wb);
        OP_PRELOAD: if (r.addr < REGS) copy_words[r.addr] = r.val;
        OP_READ: if (r.addr < REGS) e.rd = copy_words[r.addr];
        default: ;
      endcase
      e.active = (block_len != 0);
      responses_due.push_back(e);
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want,
                                logic [WORD_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(resp_t got);
      resp_t want;
      if (responses_due.size() == 0) begin
        $display("%0t: result with nothing outstanding, status %0h write %0b addr %0h",
                 $time, got.status, got.wv, got.wa);
        errors++;
        return;
      end
      want = responses_due.pop_front();
      compare_field("status", WORD_W'(want.status), WORD_W'(got.status));
      compare_field("write_valid", WORD_W'(want.wv), WORD_W'(got.wv));
      compare_field("write_address", WORD_W'(want.wa), WORD_W'(got.wa));
      compare_field("write_byte", WORD_W'(want.wb), WORD_W'(got.wb));
      compare_field("read_word", want.rd, got.rd);
      compare_field("block_active", WORD_W'(want.active), WORD_W'(got.active));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        in_opcode;
  logic [6:0]        in_buffer_index;
  logic [WORD_W-1:0] in_word_value;
  logic [REG_W-1:0]  in_reg_address;
  logic [7:0]        in_block_count;
  logic              in_eeprom_busy;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_status;
  logic              out_write_valid;
  logic [ADDR_W-1:0] out_write_address;
  logic [BYTE_W-1:0] out_write_byte;
  logic [WORD_W-1:0] out_read_word;
  logic              out_block_active;

  writer_shadow shadow = new();
  int           items_sent = 0;
  int           results_seen = 0;
  bit           steady_sender = 1'b0;  // when set, offer items back to back
  int           last_base = 0;
  int           last_cnt = 0;

  mirrored_eeprom_block_writer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_buffer_index   (in_buffer_index),
    .in_word_value     (in_word_value),
    .in_reg_address    (in_reg_address),
    .in_block_count    (in_block_count),
    .in_eeprom_busy    (in_eeprom_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_write_valid   (out_write_valid),
    .out_write_address (out_write_address),
    .out_write_byte    (out_write_byte),
    .out_read_word     (out_read_word),
    .out_block_active  (out_block_active)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fill every field at random, then let the caller pin what matters.
  function automatic req_t junk_req(logic [2:0] op);
    req_t r;
    r.op   = op;
    r.idx  = 7'($urandom);
    r.val  = WORD_W'($urandom);
    r.addr = REG_W'($urandom);
    r.cnt  = 8'($urandom);
    r.busy = 1'($urandom);
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int p;
    if (steady_sender) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one item, hold it until accepted, record it, then idle a random gap.
  task automatic send(req_t r);
    int gap;
    // Shrink a start that would be taken but reach buffer slots never loaded.
    if (r.op == OP_START && !shadow.active() && int'(r.cnt) <= BUFW &&
        int'(r.addr) + int'(r.cnt) <= REGS && int'(r.cnt) > shadow.loaded_prefix())
      r.cnt = 8'(shadow.loaded_prefix());
    in_valid        <= 1'b1;
    in_opcode       <= r.op;
    in_buffer_index <= r.idx;
    in_word_value   <= r.val;
    in_reg_address  <= r.addr;
    in_block_count  <= r.cnt;
    in_eeprom_busy  <= r.busy;
    do @(posedge clk); while (in_stall);
    shadow.note_item(r);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_poll();
    req_t r;
    r = junk_req(OP_POLL);
    r.busy = ($urandom_range(0, 99) < 25);
    send(r);
  endtask

  // Any opcode, unused ones now and then, every field random.
  task automatic send_noise();
    logic [2:0] op;
    if ($urandom_range(0, 99) < 5)
      op = 3'($urandom_range(int'(OP_READ) + 1, (1 << $bits(opcode_t)) - 1));
    else
      op = 3'($urandom_range(int'(OP_LOAD), int'(OP_READ)));
    send(junk_req(op));
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk);
  endtask

  // A well-formed block: fill the buffer, maybe line up matching copies so the
  // skip walk has work, start, then poll it to the end with some noise mixed in.
  task automatic run_block();
    int   cnt, base, match_pct, pick;
    bit   reuse;
    req_t r;
    while (shadow.active()) send_poll();
    reuse = (last_cnt > 0) && ($urandom_range(0, 99) < 30);
    if (reuse) begin
      cnt = last_cnt;
      base = last_base;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 85) cnt = $urandom_range(1, 6);
      else if (pick < 97) cnt = $urandom_range(7, 32);
      else cnt = $urandom_range(BUFW - 8, BUFW);
      pick = $urandom_range(0, 99);
      if (pick < 10) base = 0;
      else if (pick < 20) base = REGS - cnt;
      else base = $urandom_range(0, REGS - cnt);
    end
    for (int k = 0; k < cnt; k++) begin
      if (!shadow.loaded[k] || (!reuse && cnt <= 32 && $urandom_range(0, 2) == 0)) begin
        r = junk_req(OP_LOAD);
        r.idx = 7'(k);
        send(r);
      end
    end
    match_pct = (cnt > 32) ? 90 : (reuse ? 0 : $urandom_range(0, 2) * 50);
    for (int k = 1; k < cnt; k++) begin
      if ($urandom_range(0, 99) < match_pct) begin
        r = junk_req(OP_PRELOAD);
        r.addr = REG_W'(base + k);
        r.val = shadow.buf_words[k];
        send(r);
      end
    end
    r = junk_req(OP_START);
    r.addr = REG_W'(base);
    r.cnt = 8'(cnt);
    r.busy = ($urandom_range(0, 99) < 25);
    send(r);
    while (shadow.active()) begin
      if ($urandom_range(0, 99) < 85) send_poll();
      else send_noise();
    end
    last_cnt = cnt;
    last_base = base;
  endtask

  // Start a small block and walk away from it part way.
  task automatic broken_block();
    req_t r;
    r = junk_req(OP_START);
    r.cnt = 8'($urandom_range(1, 6));
    r.addr = REG_W'($urandom_range(0, REGS - int'(r.cnt)));
    send(r);
    repeat ($urandom_range(0, 5)) send_poll();
  endtask

  // Receiver: random stall runs, one long hold-off while the sender keeps going.
  initial begin
    bit held_off;
    int p;
    held_off = 1'b0;
    out_stall <= 1'b0;
    forever begin
      if (!held_off && results_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        p = $urandom_range(0, 99);
        if (p < 50) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (p < 95) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  // Check every accepted result against the oldest owed one.
  always @(posedge clk) begin
    resp_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status = status_t'(out_status);
      got.wv     = out_write_valid;
      got.wa     = out_write_address;
      got.wb     = out_write_byte;
      got.rd     = out_read_word;
      got.active = out_block_active;
      shadow.check_result(got);
      results_seen++;
    end
  end

  // Watchdog: end the run once nothing has moved on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles, %0d results still owed",
             $time, IDLE_LIMIT, shadow.outstanding());
    $display("** mirrored_eeprom_block_writer: FAILED **");
    $finish;
  end

  initial begin
    req_t r;
    int   pick;
    bit   paused;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_opcode       <= OP_POLL;
    in_buffer_index <= '0;
    in_word_value   <= '0;
    in_reg_address  <= '0;
    in_block_count  <= '0;
    in_eeprom_busy  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: erased copy at both ends of the store, idle poll, unused opcodes.
    r = junk_req(OP_READ);
    r.addr = '0;
    send(r);
    r.addr = '1;
    send(r);
    r = junk_req(OP_POLL);
    r.busy = 1'b0;
    send(r);
    for (int op = int'(OP_READ) + 1; op < (1 << $bits(opcode_t)); op++)
      send(junk_req(3'(op)));

    // Load the first slots and the top slot with extreme words.
    r = junk_req(OP_LOAD);
    r.idx = 7'd0;
    r.val = 16'h1234;
    send(r);
    r.idx = 7'd1;
    r.val = '0;
    send(r);
    r.idx = 7'd2;
    r.val = '1;
    send(r);
    r.idx = '1;
    r.val = 16'h8001;
    send(r);

    // Block at the very top of the store, started with the EEPROM busy, then a
    // second start that must be refused, a busy poll, and polls to the end.
    r = junk_req(OP_START);
    r.addr = REG_W'(REGS - 2);
    r.cnt = 8'd2;
    r.busy = 1'b1;
    send(r);
    r.addr = '0;
    r.cnt = 8'd1;
    send(r);
    r = junk_req(OP_POLL);
    r.busy = 1'b1;
    send(r);
    r.busy = 1'b0;
    while (shadow.active()) send(r);

    // Refusals: count over the buffer, block past the store, largest count.
    r = junk_req(OP_START);
    r.addr = '0;
    r.cnt = 8'(BUFW + 1);
    send(r);
    r.addr = REG_W'(REGS - 30);
    r.cnt = 8'd31;
    send(r);
    r.cnt = '1;
    send(r);
    // Zero count is taken and stays idle.
    r.addr = '0;
    r.cnt = '0;
    send(r);

    // Skip walk: copies after the first register already match the buffer.
    r = junk_req(OP_PRELOAD);
    r.addr = REG_W'(11);
    r.val = shadow.buf_words[1];
    send(r);
    r = junk_req(OP_START);
    r.addr = REG_W'(10);
    r.cnt = 8'd3;
    r.busy = 1'b0;
    send(r);
    r = junk_req(OP_POLL);
    r.busy = 1'b0;
    while (shadow.active()) send(r);
    r = junk_req(OP_PRELOAD);
    r.addr = REG_W'(5);
    r.val = 16'habcd;
    send(r);
    r = junk_req(OP_READ);
    r.addr = REG_W'(5);
    send(r);
    drain();

    // Random part: mostly whole blocks, some abandoned ones, some noise.
    paused = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      steady_sender = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) run_block();
      else if (pick < 85) broken_block();
      else repeat ($urandom_range(1, 6)) send_noise();
      if (!paused && items_sent >= ITEM_TARGET / 2) begin
        paused = 1'b1;
        drain();
      end
    end

    // Let everything owed come back, then watch for stray results.
    drain();
    repeat (SETTLE) @(posedge clk);
    shadow.errors += shadow.outstanding();

    $display("run covered %0d items and %0d results: %0d byte writes, %0d refused starts",
             items_sent, results_seen, shadow.bytes_issued, shadow.starts_refused);
    $display("mismatches and stray or missing results: %0d", shadow.errors);
    if (shadow.errors == 0) begin
      $display("** mirrored_eeprom_block_writer: PASSED **");
    end else begin
      $display("** mirrored_eeprom_block_writer: FAILED **");
    end
    $finish;
  end

endmodule
